FILE: design/vfpz_pkg.sv
// Package for the volume filtered pivot zone block: payload, zone and
// control types, fixed constants and state codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vfpz_pkg;

  // fixed algorithm constants
  localparam int unsigned PIVOT_LAG    = 3;
  localparam int unsigned WINDOW       = 5;
  localparam int unsigned MIN_BARS     = 10;
  localparam int unsigned PERIOD_LIMIT = 1000;

  // field widths
  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned ZONES_W  = 6;
  localparam int unsigned SUM_W    = 42;
  localparam int unsigned CFG_W    = 10;
  localparam int unsigned CFG_IDX_W = 1;

  // register reset values
  localparam logic [PERIOD_W-1:0] MA_PERIOD_RST = 10'd20;
  localparam logic [ZONES_W-1:0]  MAX_ZONES_RST = 6'd32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MA_PERIOD = 1'b0,
    REG_MAX_ZONES = 1'b1
  } cfg_reg_e;

  // record kinds
  localparam logic [1:0] REC_ZONE    = 2'd0;
  localparam logic [1:0] REC_END_OK  = 2'd1;
  localparam logic [1:0] REC_END_FEW = 2'd2;

  // zone types
  localparam logic ZONE_RES = 1'b0;
  localparam logic ZONE_SUP = 1'b1;

  typedef struct packed {
    logic [31:0] open_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;
    logic [31:0] bar_volume;
    logic        last_bar;
  } bar_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [31:0] pivot_bar;
    logic [31:0] found_bar;
    logic        zone_type;
    logic [31:0] level;
    logic [31:0] body_edge;
    logic [5:0]  zone_count;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [31:0] pivot;
    logic        kind;
    logic [31:0] level;
    logic [31:0] edge_price;
  } zone_t;

  // controller to datapath
  typedef struct packed {
    logic load_bar;
    logic update;
    logic store_res;
    logic store_sup;
    logic trim;
    logic zone_rd;
    logic load_zone;
    logic load_end;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit_top;
    logic hit_bot;
    logic last_bar;
    logic too_few;
    logic drain_done;
    logic out_free;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CMP,
    S_SUP,
    S_REPORT,
    S_ZRD,
    S_ZLOAD,
    S_END
  } state_e;

endpackage

`default_nettype wire

FILE: design/vfpz_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the bar input and record output channels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface vfpz_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/vfpz_ctrl.sv
// Sequencing state machine of the pivot zone block.
// Depends on vfpz_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module vfpz_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire vfpz_pkg::stat_t stat_i,
  output vfpz_pkg::cmd_t      cmd_o
);
  import vfpz_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_bar = 1'b1;
          state_d        = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.update = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        // resistance goes in before support when both fire
        if (stat_i.hit_top) begin
          cmd_o.store_res = 1'b1;
        end else if (stat_i.hit_bot) begin
          cmd_o.store_sup = 1'b1;
        end
        if (stat_i.hit_top && stat_i.hit_bot) begin
          state_d = S_SUP;
        end else begin
          state_d = stat_i.last_bar ? S_REPORT : S_IDLE;
        end
      end
      S_SUP: begin
        cmd_o.store_sup = 1'b1;
        state_d         = stat_i.last_bar ? S_REPORT : S_IDLE;
      end
      S_REPORT: begin
        if (stat_i.too_few) begin
          state_d = S_END;
        end else begin
          cmd_o.trim = 1'b1;
          state_d    = S_ZRD;
        end
      end
      S_ZRD: begin
        if (stat_i.drain_done) begin
          state_d = S_END;
        end else begin
          cmd_o.zone_rd = 1'b1;
          state_d       = S_ZLOAD;
        end
      end
      S_ZLOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load_zone = 1'b1;
          state_d         = S_ZRD;
        end
      end
      S_END: begin
        if (stat_i.out_free) begin
          cmd_o.load_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/vfpz_datapath.sv
// Datapath of the pivot zone block: registers, volume history memory,
// moving sum, fractal window, zone ring memory and output register.
// Depends on vfpz_pkg; driven by vfpz_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module vfpz_datapath #(
  parameter int unsigned MAX_PERIOD = 1024,
  parameter int unsigned CAPACITY   = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [vfpz_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [vfpz_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire vfpz_pkg::bar_t                  bar_i,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output vfpz_pkg::rec_t                       out_o,
  input  wire vfpz_pkg::cmd_t                  cmd_i,
  output vfpz_pkg::stat_t                      stat_o
);
  import vfpz_pkg::*;

  localparam int unsigned HW   = $clog2(MAX_PERIOD);
  localparam int unsigned CW   = ((HW > PERIOD_W) ? HW : PERIOD_W) + 1;
  localparam int unsigned ZW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FW   = $clog2(CAPACITY + 1);
  localparam int unsigned SW   = FW + 1;
  localparam int unsigned PLIM =
    (PERIOD_LIMIT < MAX_PERIOD - 1) ? PERIOD_LIMIT : MAX_PERIOD - 1;
  localparam logic [PERIOD_W-1:0] PLIM_V = PERIOD_W'(PLIM);
  localparam logic [ZONES_W-1:0]  CAP_V  = ZONES_W'(CAPACITY);

  // configuration
  logic [PERIOD_W-1:0] ma_q;
  logic [ZONES_W-1:0]  mz_q;
  logic [PERIOD_W-1:0] len;
  logic [ZONES_W-1:0]  mz_eff;
  logic [FW-1:0]       zlim;

  // series state
  bar_t             bar_q;
  logic [31:0]      cnt_q;
  logic [HW-1:0]    hpos_q;
  logic [SUM_W-1:0] sum_q;
  logic [31:0]      hi_q [WINDOW];
  logic [31:0]      lo_q [WINDOW];
  logic [31:0]      op_q [WINDOW-1];
  logic [31:0]      cl_q [WINDOW-1];
  logic [31:0]      vd_q [PIVOT_LAG];
  logic [31:0]      hrd_q;
  logic [31:0]      hmem [MAX_PERIOD];

  // pivot evaluation
  logic [SUM_W-1:0] prod_q;
  logic             elig_q, top_q, bot_q;
  logic [31:0]      piv_q, res_lvl_q, res_edge_q, sup_lvl_q, sup_edge_q;

  // zone ring
  logic [ZW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic [FW-1:0] k_q;
  zone_t         zmem [CAPACITY];
  zone_t         zrd_q;

  // output register
  rec_t out_q;
  logic out_valid_q;

  // combinational helpers
  logic [CW-1:0]    pos_x, len_x, old_x;
  logic [HW-1:0]    old_addr;
  logic             i_ge_lag, p_ge_len, elig;
  logic [31:0]      p;
  logic [SUM_W-1:0] prod;
  logic             top, bot, gt;
  logic [31:0]      body_top, body_bot;
  logic [SUM_W-1:0] sub_v;
  logic             full;
  logic [ZW-1:0]    h1, slot, st_head;
  logic [FW-1:0]    f1, st_fill;
  logic [SW-1:0]    f2;
  logic [ZW-1:0]    tr_head, rd_addr;
  logic [FW-1:0]    tr_fill;
  logic             out_free;
  zone_t            zw;

  function automatic logic [ZW-1:0] wrap(input logic [SW-1:0] x);
    logic [SW-1:0] r;
    r = (x >= SW'(CAPACITY)) ? x - SW'(CAPACITY) : x;
    return r[ZW-1:0];
  endfunction

  // effective register values
  always_comb begin
    if (ma_q == '0) begin
      len = PERIOD_W'(1);
    end else if (ma_q > PLIM_V) begin
      len = PLIM_V;
    end else begin
      len = ma_q;
    end
    if (mz_q == '0) begin
      mz_eff = ZONES_W'(1);
    end else if (mz_q > CAP_V) begin
      mz_eff = CAP_V;
    end else begin
      mz_eff = mz_q;
    end
    zlim = mz_eff[FW-1:0];
  end

  // oldest history slot of the average window
  always_comb begin
    pos_x = CW'(hpos_q);
    len_x = CW'(len);
    if (pos_x >= len_x) begin
      old_x = pos_x - len_x;
    end else begin
      old_x = pos_x + CW'(MAX_PERIOD) - len_x;
    end
    old_addr = old_x[HW-1:0];
  end

  // pivot qualification on the window before this bar shifts in
  assign i_ge_lag = (cnt_q >= 32'(PIVOT_LAG));
  assign p        = cnt_q - 32'(PIVOT_LAG);
  assign p_ge_len = (p >= 32'(len));
  assign elig     = (cnt_q >= 32'(WINDOW)) && ((p + 32'd1) >= 32'(len));
  assign prod     = SUM_W'(vd_q[PIVOT_LAG-1]) * SUM_W'(len);
  assign top = (hi_q[2] > hi_q[3]) && (hi_q[3] > hi_q[4]) &&
               (hi_q[1] < hi_q[2]) && (hi_q[0] < hi_q[1]);
  assign bot = (lo_q[2] < lo_q[3]) && (lo_q[3] < lo_q[4]) &&
               (lo_q[1] > lo_q[2]) && (lo_q[0] > lo_q[1]);
  assign body_top = (cl_q[2] >= op_q[2]) ? cl_q[2] : op_q[2];
  assign body_bot = (cl_q[2] >= op_q[2]) ? op_q[2] : cl_q[2];
  assign sub_v    = p_ge_len ? SUM_W'(hrd_q) : '0;
  assign gt       = (prod_q > sum_q);

  // ring pointers for a store: make room, append, then trim to the limit
  always_comb begin
    full    = (fill_q >= FW'(CAPACITY));
    h1      = full ? wrap(SW'(head_q) + SW'(1)) : head_q;
    f1      = full ? FW'(CAPACITY - 1) : fill_q;
    slot    = wrap(SW'(h1) + SW'(f1));
    f2      = SW'(f1) + SW'(1);
    st_head = h1;
    st_fill = f2[FW-1:0];
    if (f2 > SW'(zlim)) begin
      st_head = wrap(SW'(h1) + (f2 - SW'(zlim)));
      st_fill = zlim;
    end
  end

  // trim before a report
  always_comb begin
    tr_head = head_q;
    tr_fill = fill_q;
    if (fill_q > zlim) begin
      tr_head = wrap(SW'(head_q) + SW'(fill_q) - SW'(zlim));
      tr_fill = zlim;
    end
  end

  assign rd_addr  = wrap(SW'(head_q) + SW'(k_q));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    zw.pivot      = piv_q;
    zw.kind       = cmd_i.store_sup ? ZONE_SUP : ZONE_RES;
    zw.level      = cmd_i.store_sup ? sup_lvl_q : res_lvl_q;
    zw.edge_price = cmd_i.store_sup ? sup_edge_q : res_edge_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_q <= MA_PERIOD_RST;
      mz_q <= MAX_ZONES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MA_PERIOD: ma_q <= cfg_data_i[PERIOD_W-1:0];
        REG_MAX_ZONES: mz_q <= cfg_data_i[ZONES_W-1:0];
        default: ;
      endcase
    end
  end

  // history memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bar) begin
      hrd_q <= hmem[old_addr];
    end
    if (cmd_i.update && i_ge_lag) begin
      hmem[hpos_q] <= vd_q[PIVOT_LAG-1];
    end
  end

  // zone memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_res || cmd_i.store_sup) begin
      zmem[slot] <= zw;
    end
    if (cmd_i.zone_rd) begin
      zrd_q <= zmem[rd_addr];
    end
  end

  // bar latch and pivot evaluation registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_bar) begin
      bar_q <= bar_i;
    end
    if (cmd_i.update) begin
      prod_q     <= prod;
      piv_q      <= p;
      res_lvl_q  <= hi_q[2];
      res_edge_q <= body_top;
      sup_lvl_q  <= lo_q[2];
      sup_edge_q <= body_bot;
    end
  end

  // series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hpos_q <= '0;
      sum_q  <= '0;
      elig_q <= 1'b0;
      top_q  <= 1'b0;
      bot_q  <= 1'b0;
      head_q <= '0;
      fill_q <= '0;
      k_q    <= '0;
      for (int j = 0; j < WINDOW; j++) begin
        hi_q[j] <= '0;
        lo_q[j] <= '0;
      end
      for (int j = 0; j < WINDOW - 1; j++) begin
        op_q[j] <= '0;
        cl_q[j] <= '0;
      end
      for (int j = 0; j < PIVOT_LAG; j++) begin
        vd_q[j] <= '0;
      end
    end else begin
      if (cmd_i.update) begin
        if (i_ge_lag) begin
          sum_q  <= sum_q - sub_v + SUM_W'(vd_q[PIVOT_LAG-1]);
          hpos_q <= (hpos_q == HW'(MAX_PERIOD - 1)) ? '0 : hpos_q + HW'(1);
        end
        elig_q <= elig;
        top_q  <= top;
        bot_q  <= bot;
        for (int j = WINDOW - 1; j > 0; j--) begin
          hi_q[j] <= hi_q[j-1];
          lo_q[j] <= lo_q[j-1];
        end
        hi_q[0] <= bar_q.high_price;
        lo_q[0] <= bar_q.low_price;
        for (int j = WINDOW - 2; j > 0; j--) begin
          op_q[j] <= op_q[j-1];
          cl_q[j] <= cl_q[j-1];
        end
        op_q[0] <= bar_q.open_price;
        cl_q[0] <= bar_q.close_price;
        for (int j = PIVOT_LAG - 1; j > 0; j--) begin
          vd_q[j] <= vd_q[j-1];
        end
        vd_q[0] <= bar_q.bar_volume;
        if (cnt_q != '1) begin
          cnt_q <= cnt_q + 32'd1;
        end
      end
      if (cmd_i.store_res || cmd_i.store_sup) begin
        head_q <= st_head;
        fill_q <= st_fill;
      end
      if (cmd_i.trim) begin
        head_q <= tr_head;
        fill_q <= tr_fill;
        k_q    <= '0;
      end
      if (cmd_i.load_zone) begin
        k_q <= k_q + FW'(1);
      end
      // end of series clears the counters, sums, windows and zone ring pointers, not the configuration registers
      if (cmd_i.load_end) begin
        cnt_q  <= '0;
        hpos_q <= '0;
        sum_q  <= '0;
        head_q <= '0;
        fill_q <= '0;
        k_q    <= '0;
        for (int j = 0; j < WINDOW; j++) begin
          hi_q[j] <= '0;
          lo_q[j] <= '0;
        end
        for (int j = 0; j < WINDOW - 1; j++) begin
          op_q[j] <= '0;
          cl_q[j] <= '0;
        end
        for (int j = 0; j < PIVOT_LAG; j++) begin
          vd_q[j] <= '0;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_zone || cmd_i.load_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_zone) begin
      out_q.record_kind <= REC_ZONE;
      out_q.pivot_bar   <= zrd_q.pivot;
      out_q.found_bar   <= zrd_q.pivot + 32'(PIVOT_LAG);
      out_q.zone_type   <= zrd_q.kind;
      out_q.level       <= zrd_q.level;
      out_q.body_edge   <= zrd_q.edge_price;
      out_q.zone_count  <= '0;
      out_q.last        <= 1'b0;
    end else if (cmd_i.load_end) begin
      out_q.record_kind <= stat_o.too_few ? REC_END_FEW : REC_END_OK;
      out_q.pivot_bar   <= '0;
      out_q.found_bar   <= '0;
      out_q.zone_type   <= 1'b0;
      out_q.level       <= '0;
      out_q.body_edge   <= '0;
      out_q.zone_count  <= stat_o.too_few ? '0 : ZONES_W'(fill_q);
      out_q.last        <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // status
  always_comb begin
    stat_o.hit_top    = elig_q && top_q && gt;
    stat_o.hit_bot    = elig_q && bot_q && gt;
    stat_o.last_bar   = bar_q.last_bar;
    stat_o.too_few    = (cnt_q < 32'(MIN_BARS));
    stat_o.drain_done = (k_q == fill_q);
    stat_o.out_free   = out_free;
  end

endmodule

`default_nettype wire

FILE: design/volume_filtered_pivot_zones.sv
// Volume filtered five-bar pivot zone detector, top level.
// Depends on vfpz_pkg, vfpz_stream_if, vfpz_ctrl and vfpz_datapath.
//
// bar_i carries one price bar per transaction (open, high, low, close,
// volume, last_bar). rec_o carries zone records and one end record.
// The config port takes a write whenever cfg_we_i is high: index 0 is
// ma_period, index 1 is max_zones; write only while the block is idle.
//
// A bar passes accept with history read, sum update and volume compare
// with zone store, plus an extra store step when a bar yields both a
// resistance and a support zone, since the zone memory has one write
// port. The history memory read of the oldest volume sets the first
// two steps. On a last_bar of a series of at least MIN_BARS bars the
// kept zones drain oldest first through the single zone memory read
// port, then the end record; a new bar is taken again once the end
// record sits in the output register. A stalled receiver holds the
// output register and the drain waits on it. Reset clears all control
// state; no clearing pass, memories are only read where written.
`timescale 1ns / 1ps
`default_nettype none

module volume_filtered_pivot_zones #(
  parameter int unsigned MAX_PERIOD = 1024,
  parameter int unsigned CAPACITY   = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  vfpz_stream_if.sink                         bar_i,
  vfpz_stream_if.source                       rec_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [vfpz_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vfpz_pkg::CFG_W-1:0]     cfg_data_i
);
  import vfpz_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;
  rec_t  out_rec;
  bar_t  bar_in;

  assign bar_in = bar_i.payload;

  // control
  vfpz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bar_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath
  vfpz_datapath #(
    .MAX_PERIOD (MAX_PERIOD),
    .CAPACITY   (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bar_i       (bar_in),
    .out_ready_i (rec_o.ready),
    .out_valid_o (out_valid),
    .out_o       (out_rec),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

  assign bar_i.ready   = in_ready;
  assign rec_o.valid   = out_valid;
  assign rec_o.payload = out_rec;

  // an accepted bar always moves on to the sum update
  a_bar_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_bar |=> cmd.update)
    else $error("accepted bar not followed by sum update");

  // records only go into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_zone || cmd.load_end) |-> stat.out_free)
    else $error("record loaded over a pending record");

  // single zone memory write port
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.store_res && cmd.store_sup))
    else $error("two zone stores in one cycle");

  // the block is ready for the next series right after the end record
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_end |=> bar_i.ready)
    else $error("not ready after end record");

endmodule

`default_nettype wire

FILE: tb/sv/vfpz_zone_checker.sv
// Scoreboard for the volume filtered pivot zone block: tracks series state
// from bar and config transactions and checks every record transaction.
// Depends on vfpz_pkg.
`timescale 1ns / 1ps

module vfpz_zone_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           bar_valid_i,
  input  wire logic                           bar_ready_i,
  input  wire vfpz_pkg::bar_t                 bar_data_i,
  input  wire logic                           rec_valid_i,
  input  wire logic                           rec_ready_i,
  input  wire vfpz_pkg::rec_t                 rec_data_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [vfpz_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [vfpz_pkg::CFG_W-1:0]     cfg_data_i,
  output int                                  mismatches_o,
  output int                                  outstanding_o,
  output int                                  zone_recs_o,
  output int                                  end_recs_o
);
  import vfpz_pkg::*;

  localparam int unsigned HIST_DEPTH = 1024;
  localparam int unsigned ZONE_CAP   = 32;
  localparam int unsigned MAX_SHOWN  = 10;
  localparam int unsigned OWED_DEPTH = 128;

  // register copies
  logic [PERIOD_W-1:0] ma_period;
  logic [ZONES_W-1:0]  max_zones;

  // series state
  logic [31:0]      vol_hist [HIST_DEPTH];
  int unsigned      hist_wr;
  logic [SUM_W-1:0] vol_sum;
  logic [31:0]      highs    [WINDOW];
  logic [31:0]      lows     [WINDOW];
  logic [31:0]      opens    [WINDOW-1];
  logic [31:0]      closes   [WINDOW-1];
  logic [31:0]      vol_lag  [PIVOT_LAG];
  logic [31:0]      bar_count;
  zone_t            zones    [ZONE_CAP];
  int unsigned      zone_head;
  int unsigned      zone_fill;

  // records still owed by the block, oldest first, in a ring
  rec_t        owed_records [OWED_DEPTH];
  int unsigned owed_head;
  int unsigned owed_count;

  function automatic void owe_record(input rec_t r);
    owed_records[(owed_head + owed_count) % OWED_DEPTH] = r;
    owed_count++;
  endfunction

  function automatic int unsigned avg_len();
    int unsigned len;
    len = ma_period;
    if (len < 1) len = 1;
    if (len > PERIOD_LIMIT) len = PERIOD_LIMIT;
    if (len > HIST_DEPTH - 1) len = HIST_DEPTH - 1;
    return len;
  endfunction

  function automatic int unsigned zone_limit();
    int unsigned lim;
    lim = max_zones;
    if (lim < 1) lim = 1;
    if (lim > ZONE_CAP) lim = ZONE_CAP;
    return lim;
  endfunction

  function automatic void drop_oldest(input int unsigned keep);
    while (zone_fill > keep) begin
      zone_head = (zone_head + 1) % ZONE_CAP;
      zone_fill--;
    end
  endfunction

  function automatic void keep_zone(input logic [31:0] pivot, input logic kind,
                                    input logic [31:0] lvl, input logic [31:0] body);
    int unsigned slot;
    if (zone_fill >= ZONE_CAP) drop_oldest(ZONE_CAP - 1);
    slot = (zone_head + zone_fill) % ZONE_CAP;
    zones[slot].pivot      = pivot;
    zones[slot].kind       = kind;
    zones[slot].level      = lvl;
    zones[slot].edge_price = body;
    zone_fill++;
    drop_oldest(zone_limit());
  endfunction

  function automatic void clear_series();
    hist_wr   = 0;
    vol_sum   = '0;
    bar_count = '0;
    zone_head = 0;
    zone_fill = 0;
    for (int unsigned k = 0; k < WINDOW; k++) begin
      highs[k] = '0;
      lows[k]  = '0;
    end
    for (int unsigned k = 0; k < WINDOW - 1; k++) begin
      opens[k]  = '0;
      closes[k] = '0;
    end
    for (int unsigned k = 0; k < PIVOT_LAG; k++) vol_lag[k] = '0;
  endfunction

  // advance the series by one bar and queue any records it releases
  function automatic void fold_bar(input bar_t b);
    int unsigned len, idx, piv, oldest, k;
    logic [31:0] pv, po, pc;
    logic [63:0] weighted;
    rec_t r;
    len = avg_len();
    idx = bar_count;
    if (idx >= PIVOT_LAG) begin
      piv = idx - PIVOT_LAG;
      pv  = vol_lag[PIVOT_LAG-1];
      // slide the volume window so it ends at the pivot
      if (piv >= len) begin
        oldest  = (hist_wr + HIST_DEPTH - len) % HIST_DEPTH;
        vol_sum = vol_sum - SUM_W'(vol_hist[oldest]);
      end
      vol_hist[hist_wr] = pv;
      vol_sum = vol_sum + SUM_W'(pv);
      hist_wr = (hist_wr + 1) % HIST_DEPTH;
      weighted = 64'(pv) * 64'(len);
      // volume gate, then the two fractal shapes
      if (idx >= WINDOW && piv + 1 >= len && weighted > 64'(vol_sum)) begin
        po = opens[2];
        pc = closes[2];
        if (highs[2] > highs[3] && highs[3] > highs[4] &&
            highs[1] < highs[2] && highs[0] < highs[1])
          keep_zone(piv, ZONE_RES, highs[2], (pc >= po) ? pc : po);
        if (lows[2] < lows[3] && lows[3] < lows[4] &&
            lows[1] > lows[2] && lows[0] > lows[1])
          keep_zone(piv, ZONE_SUP, lows[2], (pc >= po) ? po : pc);
      end
    end

    // shift the short price and volume windows
    for (k = WINDOW - 1; k > 0; k--) begin
      highs[k] = highs[k-1];
      lows[k]  = lows[k-1];
    end
    highs[0] = b.high_price;
    lows[0]  = b.low_price;
    for (k = WINDOW - 2; k > 0; k--) begin
      opens[k]  = opens[k-1];
      closes[k] = closes[k-1];
    end
    opens[0]  = b.open_price;
    closes[0] = b.close_price;
    for (k = PIVOT_LAG - 1; k > 0; k--) vol_lag[k] = vol_lag[k-1];
    vol_lag[0] = b.bar_volume;
    if (bar_count != 32'hFFFF_FFFF) bar_count++;

    if (!b.last_bar) return;

    // series report
    if (bar_count < MIN_BARS) begin
      r = '0;
      r.record_kind = REC_END_FEW;
      r.last        = 1'b1;
      owe_record(r);
    end else begin
      drop_oldest(zone_limit());
      for (k = 0; k < zone_fill; k++) begin
        r = '0;
        r.record_kind = REC_ZONE;
        r.pivot_bar   = zones[(zone_head + k) % ZONE_CAP].pivot;
        r.found_bar   = zones[(zone_head + k) % ZONE_CAP].pivot + 32'd3;
        r.zone_type   = zones[(zone_head + k) % ZONE_CAP].kind;
        r.level       = zones[(zone_head + k) % ZONE_CAP].level;
        r.body_edge   = zones[(zone_head + k) % ZONE_CAP].edge_price;
        owe_record(r);
      end
      r = '0;
      r.record_kind = REC_END_OK;
      r.zone_count  = ZONES_W'(zone_fill);
      r.last        = 1'b1;
      owe_record(r);
    end
    clear_series();
  endfunction

  function automatic string rec_text(input rec_t r);
    return $sformatf("kind %0d pivot %0d found %0d type %0d level %h edge %h count %0d last %0d",
                     r.record_kind, r.pivot_bar, r.found_bar, r.zone_type, r.level,
                     r.body_edge, r.zone_count, r.last);
  endfunction

  function automatic void flag_record(input string what, input rec_t want, input rec_t got);
    mismatches_o++;
    if (mismatches_o <= MAX_SHOWN) begin
      $display("mismatch %0d at %0t: %s", mismatches_o, $realtime, what);
      $display("  expected %s", rec_text(want));
      $display("  actual   %s", rec_text(got));
    end
  endfunction

  // watch both channels and the config port
  always @(posedge clk_i or negedge rst_ni) begin
    rec_t got, want;
    if (!rst_ni) begin
      ma_period     = MA_PERIOD_RST;
      max_zones     = MAX_ZONES_RST;
      owed_head     = 0;
      owed_count    = 0;
      clear_series();
      mismatches_o  = 0;
      outstanding_o = 0;
      zone_recs_o   = 0;
      end_recs_o    = 0;
    end else begin
      // record transaction against the oldest owed record
      if (rec_valid_i && rec_ready_i) begin
        got = rec_data_i;
        if (got.last) end_recs_o++;
        else zone_recs_o++;
        if (owed_count == 0) begin
          flag_record("record with nothing outstanding", '0, got);
        end else begin
          want       = owed_records[owed_head];
          owed_head  = (owed_head + 1) % OWED_DEPTH;
          owed_count--;
          if (got.record_kind !== want.record_kind || got.pivot_bar !== want.pivot_bar ||
              got.found_bar !== want.found_bar || got.zone_type !== want.zone_type ||
              got.level !== want.level || got.body_edge !== want.body_edge ||
              got.zone_count !== want.zone_count || got.last !== want.last)
            flag_record("record fields differ", want, got);
        end
      end
      // bar transaction
      if (bar_valid_i && bar_ready_i) fold_bar(bar_data_i);
      // register write
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_MA_PERIOD: ma_period = cfg_data_i[PERIOD_W-1:0];
          REG_MAX_ZONES: max_zones = cfg_data_i[ZONES_W-1:0];
          default: ;
        endcase
      end
      outstanding_o = owed_count;
    end
  end

endmodule

FILE: tb/sv/tb_volume_filtered_pivot_zones.sv
// Top of the pivot zone testbench: clock, reset, bar and config stimulus,
// record back-pressure and the verdict. Depends on vfpz_pkg, vfpz_stream_if,
// volume_filtered_pivot_zones and vfpz_zone_checker.
`timescale 1ns / 1ps

module tb_volume_filtered_pivot_zones;
  import vfpz_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef enum int {
    SHAPE_ZIGZAG,
    SHAPE_WALK,
    SHAPE_NOISE
  } shape_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int          mismatches;
  int          outstanding;
  int          zone_recs;
  int          end_recs;
  int          bars_sent;
  bit          steady;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned stall_left;

  vfpz_stream_if #(.payload_t(bar_t)) bar_if ();
  vfpz_stream_if #(.payload_t(rec_t)) rec_if ();

  volume_filtered_pivot_zones uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .bar_i      (bar_if),
    .rec_o      (rec_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  vfpz_zone_checker zone_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bar_valid_i  (bar_if.valid),
    .bar_ready_i  (bar_if.ready),
    .bar_data_i   (bar_if.payload),
    .rec_valid_i  (rec_if.valid),
    .rec_ready_i  (rec_if.ready),
    .rec_data_i   (rec_if.payload),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .outstanding_o(outstanding),
    .zone_recs_o  (zone_recs),
    .end_recs_o   (end_recs)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bar_t bar_of(input logic [31:0] o, input logic [31:0] h,
                                  input logic [31:0] l, input logic [31:0] c,
                                  input logic [31:0] v, input logic lb);
    bar_t b;
    b.open_price  = o;
    b.high_price  = h;
    b.low_price   = l;
    b.close_price = c;
    b.bar_volume  = v;
    b.last_bar    = lb;
    return b;
  endfunction

  // one bar transaction, with an optional gap ahead of it
  task automatic send_bar(input bar_t b);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      bar_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    bar_if.payload <= b;
    bar_if.valid   <= 1'b1;
    @(posedge clk_i);
    while (!bar_if.ready) @(posedge clk_i);
    bars_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] zone_max);
    write_reg(REG_MA_PERIOD, period);
    write_reg(REG_MAX_ZONES, zone_max);
  endtask

  // drop valid and wait until every owed record has come back
  task automatic settle();
    bar_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one series of bars ending in a last bar
  task automatic run_series(input shape_e shape, input int unsigned n_bars);
    logic [31:0] base, unit, spread, hi, lo;
    int unsigned phase, m, t, k;
    bar_t b;
    base   = $urandom_range(32'hF000_0000, 32'h0010_0000);
    unit   = $urandom_range(1, 200);
    spread = $urandom_range(0, 999);
    phase  = $urandom_range(0, 3);
    for (k = 0; k < n_bars; k++) begin
      case (shape)
        // triangle wave: a top and a bottom fractal every four bars
        SHAPE_ZIGZAG: begin
          m  = (k + phase) % 4;
          t  = (m == 3) ? 1 : m;
          hi = base + unit * t;
          if ($urandom_range(0, 9) == 0) hi = hi + $urandom_range(0, 2 * unit);
          lo = hi - spread;
          b.high_price  = hi;
          b.low_price   = lo;
          b.open_price  = lo + $urandom_range(0, hi - lo);
          b.close_price = lo + $urandom_range(0, hi - lo);
          b.bar_volume  = (t == 1) ? $urandom_range(0, 20000) : $urandom_range(40000, 90000);
          if ($urandom_range(0, 15) == 0) b.bar_volume = $urandom();
          b.last_bar    = (k == n_bars - 1);
        end
        // small random walk, fractals now and then
        SHAPE_WALK: begin
          base = base + $urandom_range(0, 600) - 300;
          hi   = base + $urandom_range(0, 300);
          lo   = base - $urandom_range(0, 300);
          b.high_price  = hi;
          b.low_price   = lo;
          b.open_price  = lo + $urandom_range(0, hi - lo);
          b.close_price = lo + $urandom_range(0, hi - lo);
          b.bar_volume  = $urandom_range(0, 100000);
          b.last_bar    = (k == n_bars - 1);
        end
        // raw fields, early series ends included
        default: begin
          b.open_price  = $urandom();
          b.high_price  = $urandom();
          b.low_price   = $urandom();
          b.close_price = $urandom();
          b.bar_volume  = $urandom();
          b.last_bar    = (k == n_bars - 1) || ($urandom_range(0, 7) == 0);
        end
      endcase
      send_bar(b);
    end
  endtask

  // record side back-pressure
  initial begin
    rec_if.ready <= 1'b0;
    hold_left  = 0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        rec_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && rec_if.valid) begin
        // long hold-off so the block backs up into the bar channel
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        rec_if.ready <= 1'b0;
      end else if (steady) begin
        rec_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        rec_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rec_if.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned k;
    bar_if.valid   <= 1'b0;
    bar_if.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_MA_PERIOD;
    cfg_data       <= '0;
    rst_ni         <= 1'b0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    bars_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one bar that is also the last, all fields at their top
    send_bar(bar_of('1, '1, '1, '1, '1, 1'b1));
    // nine zero bars: one short of a full report
    for (k = 0; k < 9; k++) send_bar(bar_of('0, '0, '0, '0, '0, k == 8));
    settle();

    // exactly ten bars, top and bottom fractal on one pivot at the extremes
    set_regs(10'd2, 10'd32);
    send_bar(bar_of(32'd5, 32'd10, 32'd9, 32'd6, '0, 1'b0));
    send_bar(bar_of(32'd7, 32'd20, 32'd8, 32'd8, '0, 1'b0));
    send_bar(bar_of(32'h100, '1, '0, 32'hFFFF_FFF0, '1, 1'b0));
    send_bar(bar_of(32'd12, 32'd20, 32'd8, 32'd9, '0, 1'b0));
    send_bar(bar_of(32'd9, 32'd10, 32'd9, 32'd10, '0, 1'b0));
    for (k = 0; k < 5; k++) send_bar(bar_of(32'd9, 32'd10, 32'd9, 32'd10, 32'd1, k == 4));
    settle();

    // dense zones, then a zone limit that drops the oldest
    set_regs(10'd5, 10'd32);
    run_series(SHAPE_ZIGZAG, 16);
    settle();
    set_regs(10'd2, 10'd3);
    run_series(SHAPE_ZIGZAG, 14);
    settle();

    // smallest period and zone limit, then both written as zero
    steady = 1'b1;
    set_regs(10'd1, 10'd1);
    run_series(SHAPE_WALK, 10);
    settle();
    steady = 1'b0;
    set_regs(10'd0, 10'd0);
    run_series(SHAPE_NOISE, 10);
    settle();

    // more zones than the store holds, with the receiver held off
    set_regs(10'd2, 10'd63);
    hold_req = 1'b1;
    run_series(SHAPE_ZIGZAG, 76);
    run_series(SHAPE_WALK, 6);
    settle();

    // largest periods
    set_regs(10'd1000, 10'd16);
    run_series(SHAPE_WALK, 10);
    settle();
    set_regs(10'd1023, 10'd33);
    run_series(SHAPE_NOISE, 10);
    settle();

    // one random setting
    repeat (1) begin
      set_regs(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 40)));
      steady = $urandom_range(0, 1);
      run_series(shape_e'($urandom_range(0, 2)), $urandom_range(10, 14));
      settle();
    end
    steady = 1'b0;

    $display("covered %0d bars; %0d zone records and %0d end records compared",
             bars_sent, zone_recs, end_recs);
    $display("periods 0..1023 and zone limits 0..63, zone store overflow, long output stall");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d records mismatched", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
